/* design/ids_pkg.sv */
package ids_pkg;

  // Fixed widths of the per-line counters.
  localparam int LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

  // Byte codes that steer the scanner.
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Keyword length, and the letter that each keyword position must match.
  localparam logic [2:0] KW_LEN = 3'd7;

  // One finished name, as handed from the scanner to the output side.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } desc_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0: c = "i";
      3'd1: c = "n";
      3'd2: c = "c";
      3'd3: c = "l";
      3'd4: c = "u";
      3'd5: c = "d";
      3'd6: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ASCII white space in the C locale.
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // ASCII punctuation in the C locale.
  function automatic logic is_punct(input logic [7:0] b);
    return ((b >= 8'h21) && (b <= 8'h2F)) || ((b >= 8'h3A) && (b <= 8'h40)) ||
           ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h7E));
  endfunction

endpackage

/* design/ids_ram.sv */
module ids_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds without rd_en.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/ids_front.sv */
module ids_front #(
  parameter int NAME_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [7:0]                       text_byte,
  input  logic                             end_of_input,
  output logic                             wr_en,
  output logic [$clog2(2*NAME_DEPTH)-1:0]  wr_addr,
  output logic [7:0]                       wr_data,
  output logic                             push,
  output ids_pkg::desc_t                   push_desc
);
  import ids_pkg::*;

  localparam int AW = $clog2(2*NAME_DEPTH);
  localparam int IW = $clog2(NAME_DEPTH);

  typedef enum logic [2:0] {
    PH_LEAD, PH_LEAD2, PH_KEY, PH_AFTERKEY, PH_DROSS, PH_NAME, PH_IGNORE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       kw_pos_r, kw_pos_nxt;
  logic [LEN_W-1:0] name_len_r, name_len_nxt;
  logic [LEN_W-1:0] kept_r, kept_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;

  logic             eol, nul, sp, pu;
  logic [2:0]       kw_k;
  logic             kw_hit;
  logic [LEN_W-1:0] len_inc;
  logic [LEN_W-1:0] emit_len;
  logic             emit_req;
  logic [IW-1:0]    wr_idx;

  // Byte classification.
  assign eol = end_of_input || (text_byte == CH_NL);
  assign nul = (text_byte == CH_NUL);
  assign sp  = is_space(text_byte);
  assign pu  = is_punct(text_byte);

  // Keyword match; lead phases always try the first letter.
  assign kw_k   = (phase_r == PH_KEY) ? kw_pos_r : 3'd0;
  assign kw_hit = (kw_k < KW_LEN) && ((text_byte | CASE_BIT) == kw_char(kw_k));

  assign len_inc  = (name_len_r == LEN_MAX) ? name_len_r : name_len_r + 1'b1;
  assign emit_len = (kept_r > LEN_W'(NAME_DEPTH)) ? LEN_W'(NAME_DEPTH) : kept_r;

  // Next scanner state for an accepted byte.
  always_comb begin
    phase_nxt    = phase_r;
    kw_pos_nxt   = kw_pos_r;
    name_len_nxt = name_len_r;
    kept_nxt     = kept_r;
    ovf_nxt      = ovf_r;
    emit_req     = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = '0;
    if (accept) begin
      if (eol || nul) begin
        emit_req     = (phase_r == PH_NAME);
        name_len_nxt = '0;
        kept_nxt     = '0;
        ovf_nxt      = 1'b0;
        kw_pos_nxt   = 3'd0;
        phase_nxt    = eol ? PH_LEAD : PH_IGNORE;
      end else begin
        unique case (phase_r)
          PH_LEAD, PH_LEAD2, PH_KEY: begin
            if ((phase_r != PH_KEY) && sp) begin
              phase_nxt = phase_r;
            end else if ((phase_r == PH_LEAD) && pu) begin
              phase_nxt = PH_LEAD2;
            end else if (kw_hit && (kw_k + 3'd1 == KW_LEN)) begin
              kw_pos_nxt = 3'd0;
              phase_nxt  = PH_AFTERKEY;
            end else if (kw_hit) begin
              kw_pos_nxt = kw_k + 3'd1;
              phase_nxt  = PH_KEY;
            end else begin
              kw_pos_nxt = 3'd0;
              phase_nxt  = PH_IGNORE;
            end
          end
          PH_AFTERKEY: begin
            phase_nxt = (sp || pu) ? PH_DROSS : PH_IGNORE;
          end
          PH_DROSS: begin
            if (!(sp || pu)) begin
              wr_en        = 1'b1;
              wr_idx       = '0;
              name_len_nxt = LEN_W'(1);
              kept_nxt     = LEN_W'(1);
              ovf_nxt      = 1'b0;
              phase_nxt    = PH_NAME;
            end
          end
          PH_NAME: begin
            if (sp) begin
              emit_req     = 1'b1;
              name_len_nxt = '0;
              kept_nxt     = '0;
              ovf_nxt      = 1'b0;
              phase_nxt    = PH_IGNORE;
            end else begin
              wr_en        = (name_len_r < LEN_W'(NAME_DEPTH));
              wr_idx       = name_len_r[IW-1:0];
              name_len_nxt = len_inc;
              if (!pu) begin
                kept_nxt = len_inc;
                ovf_nxt  = ovf_r || (len_inc > LEN_W'(NAME_DEPTH));
              end
            end
          end
          default: begin
            phase_nxt = PH_IGNORE;
          end
        endcase
      end
    end
  end

  // A name that strips to nothing is dropped; otherwise its bank is handed over.
  assign push           = emit_req && (emit_len != '0);
  assign push_desc.bank = bank_r;
  assign push_desc.len  = emit_len;
  assign push_desc.ovf  = ovf_r;
  assign bank_nxt       = push ? ~bank_r : bank_r;

  assign wr_addr = AW'(wr_idx) + (bank_r ? AW'(NAME_DEPTH) : AW'(0));
  assign wr_data = text_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      kw_pos_r   <= 3'd0;
      name_len_r <= '0;
      kept_r     <= '0;
      ovf_r      <= 1'b0;
      bank_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      kw_pos_r   <= kw_pos_nxt;
      name_len_r <= name_len_nxt;
      kept_r     <= kept_nxt;
      ovf_r      <= ovf_nxt;
      bank_r     <= bank_nxt;
    end
  end

endmodule

/* design/ids_queue.sv */
module ids_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ids_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output ids_pkg::desc_t head_desc,
  output logic           full
);
  import ids_pkg::*;

  desc_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head_valid = (count_r != 2'd0);
  assign head_desc  = entry_r[rd_ptr_r];
  assign full       = (count_r == 2'd2);

  // Two-entry queue of finished names, one per name buffer bank.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/ids_back.sv */
module ids_back #(
  parameter int NAME_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  ids_pkg::desc_t                  head_desc,
  output logic                            head_pop,
  output logic                            rd_en,
  output logic [$clog2(2*NAME_DEPTH)-1:0] rd_addr,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic                            out_name_last,
  output logic                            out_name_truncated
);
  import ids_pkg::*;

  localparam int AW = $clog2(2*NAME_DEPTH);

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic             last_r, last_nxt;
  logic             trunc_r, trunc_nxt;
  logic             taken;
  logic             last_byte;

  // The output slot frees when its transfer completes, so a read can refill it.
  assign taken     = out_pop && valid_r;
  assign rd_en     = head_valid && (!valid_r || taken);
  assign last_byte = (idx_r + 1'b1 == head_desc.len);
  assign head_pop  = rd_en && last_byte;
  assign rd_addr   = AW'(idx_r) + (head_desc.bank ? AW'(NAME_DEPTH) : AW'(0));

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    last_nxt  = last_r;
    trunc_nxt = trunc_r;
    if (rd_en) begin
      idx_nxt   = last_byte ? '0 : idx_r + 1'b1;
      valid_nxt = 1'b1;
      last_nxt  = last_byte;
      trunc_nxt = head_desc.ovf;
    end else if (taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    trunc_r <= trunc_nxt;
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_empty          = !valid_r;
  assign out_name_last      = last_r;
  assign out_name_truncated = trunc_r;

endmodule

/* design/include_directive_scanner.sv */
// A finished name is registered in the name queue, then read out on the registered
// buffer port, one byte per cycle while each result byte is popped.
// Throughput: one text byte per cycle; input stalls only while both name buffer
// banks hold names that are still being drained.
// Reset (synchronous, rst_n low) returns the scanner to the start of a line and
// empties the name queue and the result slot; the name buffer is not cleared.
module include_directive_scanner #(
  parameter int NAME_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_name_byte,
  output logic       out_name_last,
  output logic       out_name_truncated
);
  import ids_pkg::*;

  localparam int AW = $clog2(2*NAME_DEPTH);

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          push;
  desc_t         push_desc;
  logic          head_valid;
  desc_t         head_desc;
  logic          head_pop;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign accept = in_push && !in_full;

  // Scanner: classifies bytes and fills the name buffer.
  ids_front #(.NAME_DEPTH(NAME_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_text_byte),
    .end_of_input (in_end_of_input),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_desc    (push_desc)
  );

  // Queue of finished names between scanner and output side.
  ids_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .full       (in_full)
  );

  // Two banks of name storage.
  ids_ram #(.WIDTH(8), .DEPTH(2*NAME_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_name_byte)
  );

  // Output side: reads names out byte by byte.
  ids_back #(.NAME_DEPTH(NAME_DEPTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_desc          (head_desc),
    .head_pop           (head_pop),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_name_last      (out_name_last),
    .out_name_truncated (out_name_truncated)
  );

endmodule
